// ----- src/epx_pkg.sv -----
// Shared types and constants for the EPX 2x pixel upscaler.
package epx_pkg;

   localparam int EPX_MAX_WIDTH  = 1024;
   localparam int EPX_MAX_HEIGHT = 1024;
   localparam int EPX_PIXEL_BITS = 32;

   localparam int PIX_FIELD_W = 32;
   localparam int POS_FIELD_W = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam int CFG_WIDTH_RESET  = 64;
   localparam int CFG_HEIGHT_RESET = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [PIX_FIELD_W-1:0] pixel_value;
      logic                   drain;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_FIELD_W-1:0] out_top_left;
      logic [PIX_FIELD_W-1:0] out_top_right;
      logic [PIX_FIELD_W-1:0] out_bottom_left;
      logic [PIX_FIELD_W-1:0] out_bottom_right;
      logic [POS_FIELD_W-1:0] src_col;
      logic [POS_FIELD_W-1:0] src_row;
      logic                   last_of_frame;
   } rsp_payload_type;

   // Center pixel and its four neighbors: above, right, left, below.
   typedef struct packed {
      logic [PIX_FIELD_W-1:0] p;
      logic [PIX_FIELD_W-1:0] a;
      logic [PIX_FIELD_W-1:0] b;
      logic [PIX_FIELD_W-1:0] c;
      logic [PIX_FIELD_W-1:0] d;
   } nbhd_type;

   typedef struct packed {
      logic [PIX_FIELD_W-1:0] p1;
      logic [PIX_FIELD_W-1:0] p2;
      logic [PIX_FIELD_W-1:0] p3;
      logic [PIX_FIELD_W-1:0] p4;
   } block_type;

endpackage

// ----- src/epx_line_ram.sv -----
// Line store: one write port, one registered read port, write-first on collision.
module epx_line_ram
   import epx_pkg::*;
#(
   parameter int DEPTH  = EPX_MAX_WIDTH,
   parameter int DATA_W = EPX_PIXEL_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/epx_block_rule.sv -----
// EPX rule: builds the 2x2 output block from a pixel and its four neighbors.
module epx_block_rule
   import epx_pkg::*;
(
   input  nbhd_type  nbhd,
   output block_type blk
);

   logic ca_eq, ab_eq, bd_eq, cd_eq;

   assign ca_eq = (nbhd.c == nbhd.a);
   assign ab_eq = (nbhd.a == nbhd.b);
   assign bd_eq = (nbhd.b == nbhd.d);
   assign cd_eq = (nbhd.c == nbhd.d);

   always_comb begin
      blk.p1 = (ca_eq && !cd_eq && !ab_eq) ? nbhd.a : nbhd.p;
      blk.p2 = (ab_eq && !ca_eq && !bd_eq) ? nbhd.b : nbhd.p;
      blk.p3 = (cd_eq && !bd_eq && !ca_eq) ? nbhd.c : nbhd.p;
      blk.p4 = (bd_eq && !ab_eq && !cd_eq) ? nbhd.d : nbhd.p;
   end

endmodule

// ----- src/epx_pixel_upscaler_unit.sv -----
// Top level of the EPX 2x pixel upscaler: counters, line stores, result register.
//
//   port group   direction  handshake              payload
//   req_         in         req_valid/req_ready    req_payload (pixel_value, drain)
//   rsp_         out        rsp_valid/rsp_ready    rsp_payload (2x2 block, position, last)
//   csr_         in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One item per clock while req_ready is high; a result appears in the output register the cycle after its transfer.
// Line store reads are prefetched each cycle at the next column, so the store read
// port sets the one-cycle pace. req_ready drops only while a result waits with rsp_ready low.
// Reset clears counters and state; line stores are not cleared and need no sweep.
// A write to the width or height register restarts the frame; csr_ready is always high.
module epx_pixel_upscaler_unit
   import epx_pkg::*;
#(
   parameter int MAX_WIDTH  = EPX_MAX_WIDTH,
   parameter int MAX_HEIGHT = EPX_MAX_HEIGHT,
   parameter int PIXEL_BITS = EPX_PIXEL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WIDTH_RST_LAST =
      ((CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET) - 1;
   localparam int HEIGHT_RST_LAST =
      ((CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET) - 1;

   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  draining_ff, draining_in;
   logic [COL_W-1:0]      wlast_ff, wlast_in;
   logic [ROW_W-1:0]      hlast_ff, hlast_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  req_xfer, csr_hit;
   logic                  pix_go, drn_go, emit;
   logic                  x_last, y_last;
   logic [PIXEL_BITS-1:0] pix;
   logic [PIXEL_BITS-1:0] ram_p_q, ram_b_q, ram_a_q;
   logic [PIXEL_BITS-1:0] nb_p, nb_a, nb_b, nb_c, nb_d;
   logic [COL_W-1:0]      rd_addr_b;
   logic [COL_W-1:0]      wlast_wr;
   logic [ROW_W-1:0]      hlast_wr;
   nbhd_type              nbhd;
   block_type             blk;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_xfer = req_valid && req_ready;
   assign csr_hit  = csr_valid &&
                     ((csr_index == REG_IMAGE_WIDTH) || (csr_index == REG_IMAGE_HEIGHT));

   assign pix    = req_payload.pixel_value[PIXEL_BITS-1:0];
   assign x_last = (col_ff == wlast_ff);
   assign y_last = (row_ff == hlast_ff);
   // a drain in pixel phase, or a pixel in drain phase, is dropped
   assign pix_go = req_xfer && !draining_ff && !req_payload.drain;
   assign drn_go = req_xfer && draining_ff && req_payload.drain;
   assign emit   = drn_go || (pix_go && (row_ff != '0));

   // register value to last index, clamped to [1, max]
   always_comb begin
      if (csr_wdata == '0) begin
         wlast_wr = '0;
         hlast_wr = '0;
      end else begin
         wlast_wr = (32'(csr_wdata) > 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1)
                                                      : COL_W'(csr_wdata - 1'b1);
         hlast_wr = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1)
                                                       : ROW_W'(csr_wdata - 1'b1);
      end
   end

   // neighborhood; missing neighbors at the border fall back to the center
   always_comb begin
      nb_p = ram_p_q;
      nb_b = x_last ? nb_p : ram_b_q;
      nb_c = (col_ff == '0) ? nb_p : left_ff;
      if (draining_ff) begin
         nb_a = (hlast_ff != '0) ? ram_a_q : nb_p;
         nb_d = nb_p;
      end else begin
         nb_a = (row_ff > ROW_W'(1)) ? ram_a_q : nb_p;
         nb_d = pix;
      end
      nbhd.p = PIX_FIELD_W'(nb_p);
      nbhd.a = PIX_FIELD_W'(nb_a);
      nbhd.b = PIX_FIELD_W'(nb_b);
      nbhd.c = PIX_FIELD_W'(nb_c);
      nbhd.d = PIX_FIELD_W'(nb_d);
   end

   epx_block_rule u_rule (
      .nbhd (nbhd),
      .blk  (blk)
   );

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      wlast_in    = wlast_ff;
      hlast_in    = hlast_ff;
      if (csr_hit) begin
         col_in      = '0;
         row_in      = '0;
         draining_in = 1'b0;
         if (csr_index == REG_IMAGE_WIDTH) begin
            wlast_in = wlast_wr;
         end else begin
            hlast_in = hlast_wr;
         end
      end else if (pix_go) begin
         if (x_last) begin
            col_in = '0;
            if (y_last) begin
               row_in      = '0;
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else if (drn_go) begin
         if (x_last) begin
            col_in      = '0;
            row_in      = '0;
            draining_in = 1'b0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign left_in = emit ? nb_p : left_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.out_top_left     = blk.p1;
         rsp_in.out_top_right    = blk.p2;
         rsp_in.out_bottom_left  = blk.p3;
         rsp_in.out_bottom_right = blk.p4;
         rsp_in.src_col          = POS_FIELD_W'(col_ff);
         rsp_in.src_row          = draining_ff ? POS_FIELD_W'(hlast_ff)
                                               : POS_FIELD_W'(row_ff - 1'b1);
         rsp_in.last_of_frame    = draining_ff && x_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         draining_ff  <= 1'b0;
         wlast_ff     <= COL_W'(WIDTH_RST_LAST);
         hlast_ff     <= ROW_W'(HEIGHT_RST_LAST);
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         draining_ff  <= draining_in;
         wlast_ff     <= wlast_in;
         hlast_ff     <= hlast_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // prefetch for the column of the next cycle; past the last column the read is unused
   assign rd_addr_b = col_in + 1'b1;

   // last complete row, two replicas for the center and right-neighbor reads
   epx_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIXEL_BITS)) u_prev_center (
      .clock   (clock),
      .wr_en   (pix_go),
      .wr_addr (col_ff),
      .wr_data (pix),
      .rd_addr (col_in),
      .rd_data (ram_p_q)
   );

   epx_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIXEL_BITS)) u_prev_right (
      .clock   (clock),
      .wr_en   (pix_go),
      .wr_addr (col_ff),
      .wr_data (pix),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b_q)
   );

   // the row above the last complete row
   epx_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIXEL_BITS)) u_older (
      .clock   (clock),
      .wr_en   (pix_go && (row_ff != '0)),
      .wr_addr (col_ff),
      .wr_data (nb_p),
      .rd_addr (col_in),
      .rd_data (ram_a_q)
   );

endmodule

// ----- src/epx_port_checker.sv -----
// Port-level checks for the EPX upscaler, bound to the top level.
module epx_port_checker
   import epx_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_payload_type        rsp_payload
);

   // a held result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp_payload changed while stalled");

   // output register empty means the input side is open
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output register");

   // a new result only follows an input transfer in the previous cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready))
      else $error("result without a preceding input transfer");

endmodule

bind epx_pixel_upscaler_unit epx_port_checker u_port_checker (.*);
